// ===== hw/rtl/ssbpd_pkg.sv =====
// Shared types, constants and lookup tables for the seven-segment blink plane driver.
// No dependencies; every other file of the block imports this package.
package ssbpd_pkg;

  localparam int REGISTER_COUNT = 9;
  localparam int RegIdxW        = $clog2(REGISTER_COUNT);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPtrW          = $clog2(QUEUE_DEPTH);
  localparam int QCntW          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] GLYPH_COUNT = 6'd40;
  localparam logic [2:0] LAST_STEP   = 3'd6;

  // Input kinds; the numeric values match the mode field.
  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_SEG   = 3'd1,
    MODE_GLYPH = 3'd2,
    MODE_FILL  = 3'd3,
    MODE_REQ   = 3'd4
  } cmd_kind_t;

  // Display modes; bit n drives plane n.
  localparam logic [1:0] DMODE_OFF     = 2'd0;
  localparam logic [1:0] DMODE_BLINK_A = 2'd1;
  localparam logic [1:0] DMODE_BLINK_B = 2'd2;
  localparam logic [1:0] DMODE_ON      = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_BLINK_FRAMES = 1'b0;
  localparam logic CFG_UPSIDE_DOWN  = 1'b1;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] seg;
    logic [6:0] bits;
    logic [5:0] base;
    logic       flip;
    logic [1:0] dmode;
  } cmd_t;

  function automatic logic [6:0] glyph_bits(input logic [5:0] code);
    logic [6:0] g;
    case (code)
      6'd0:  g = 7'h77;  6'd1:  g = 7'h06;  6'd2:  g = 7'h6B;  6'd3:  g = 7'h4F;
      6'd4:  g = 7'h1E;  6'd5:  g = 7'h5D;  6'd6:  g = 7'h7D;  6'd7:  g = 7'h07;
      6'd8:  g = 7'h7F;  6'd9:  g = 7'h5F;  6'd10: g = 7'h3F;  6'd11: g = 7'h7C;
      6'd12: g = 7'h71;  6'd13: g = 7'h6E;  6'd14: g = 7'h79;  6'd15: g = 7'h39;
      6'd16: g = 7'h1B;  6'd17: g = 7'h2C;  6'd18: g = 7'h3B;  6'd19: g = 7'h3E;
      6'd20: g = 7'h30;  6'd21: g = 7'h40;  6'd22: g = 7'h08;  6'd23: g = 7'h01;
      6'd24: g = 7'h48;  6'd25: g = 7'h09;  6'd26: g = 7'h41;  6'd27: g = 7'h49;
      6'd28: g = 7'h28;  6'd29: g = 7'h2C;  6'd30: g = 7'h20;  6'd31: g = 7'h6C;
      6'd32: g = 7'h00;  6'd33: g = 7'h33;  6'd34: g = 7'h17;  6'd35: g = 7'h70;
      6'd36: g = 7'h68;  6'd37: g = 7'h76;  6'd38: g = 7'h78;  6'd39: g = 7'h5E;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  function automatic logic [5:0] field_base(input logic [1:0] pos);
    logic [5:0] b;
    case (pos)
      2'd0:    b = 6'd40;
      2'd1:    b = 6'd36;
      2'd2:    b = 6'd31;
      default: b = 6'd27;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] seg_offset(input logic [2:0] idx);
    logic [4:0] o;
    case (idx)
      3'd0:    o = 5'd2;
      3'd1:    o = 5'd3;
      3'd2:    o = 5'd27;
      3'd3:    o = 5'd1;
      3'd4:    o = 5'd0;
      3'd5:    o = 5'd24;
      3'd6:    o = 5'd25;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

// ===== hw/rtl/seven_segment_blink_plane_driver.sv =====
// Top level of the seven-segment blink plane driver: configuration registers
// and the front end, queue and back end. Depends on ssbpd_pkg and its submodules.
//
//   channel  direction  transfer                 payload
//   s_axis   in         tvalid & tready          tuser: mode; tdata: item fields
//   m_axis   out        tvalid & tready          tuser: write_valid; tdata; tlast
//   cfg      in         cfg_we high              cfg_index, cfg_data
//
// A set segment, fill or update request is handled at dispatch; a character is dispatched
// and then written one segment per cycle by the glyph sequencer; a tick emits 1 or 9
// beats, one per cycle through the single output register while the output does not stall.
// The front end registers each item; the two-entry queue lets the front
// keep accepting while the back end is busy or the output stalls.
// Reset (synchronous) clears both planes, counters, flags and all valid bits.
module seven_segment_blink_plane_driver import ssbpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // seg_index[6:0], char_code[12:7], position[14:13],
                                      // display_mode[16:15], zero fill[23:17]
  input  logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // reg_index[3:0], reg_data[11:4], frames_needed[12],
                                      // zero fill[15:13]
  output logic        m_axis_tuser,   // write_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] blink_frames;
  logic       upside_down;
  logic       f_valid;
  logic       f_ready;
  cmd_t       f_cmd;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  logic [3:0] reg_index;
  logic [7:0] reg_data;
  logic       frames_needed;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_frames <= 8'd12;
      upside_down  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_FRAMES: blink_frames <= cfg_data;
        CFG_UPSIDE_DOWN:  upside_down  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ssbpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .mode         (s_axis_tuser),
    .seg_index    (s_axis_tdata[6:0]),
    .char_code    (s_axis_tdata[12:7]),
    .position     (s_axis_tdata[14:13]),
    .display_mode (s_axis_tdata[16:15]),
    .upside_down  (upside_down),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd          (f_cmd)
  );

  ssbpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  ssbpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_cmd         (q_cmd),
    .blink_frames  (blink_frames),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .write_valid   (m_axis_tuser),
    .reg_index     (reg_index),
    .reg_data      (reg_data),
    .frames_needed (frames_needed),
    .last          (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, frames_needed, reg_data, reg_index};

endmodule

// ===== hw/rtl/ssbpd_front.sv =====
// Front end: accepts input beats, drops ignored items and decodes glyph writes.
// Depends on ssbpd_pkg; feeds ssbpd_queue.
module ssbpd_front import ssbpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [6:0] seg_index,
  input  logic [5:0] char_code,
  input  logic [1:0] position,
  input  logic [1:0] display_mode,
  input  logic       upside_down,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  logic   keep;
  logic   accept;
  logic   push;
  logic [1:0] pos_eff;
  cmd_t   decoded;

  assign push     = cmd_valid && cmd_ready;
  assign in_ready = !cmd_valid || cmd_ready;
  assign accept   = in_valid && in_ready;

  // Unused modes and glyph codes beyond the table never reach the back end.
  assign keep = (mode <= MODE_REQ) && !((mode == MODE_GLYPH) && (char_code >= GLYPH_COUNT));

  // Mirroring a 2-bit position p to 3-p is a bitwise inversion.
  assign pos_eff = upside_down ? ~position : position;

  always_comb begin
    decoded.kind  = cmd_kind_t'(mode);
    decoded.seg   = seg_index;
    decoded.bits  = glyph_bits(char_code);
    decoded.base  = field_base(pos_eff);
    decoded.flip  = upside_down;
    decoded.dmode = display_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (accept) cmd_valid <= keep;
      else if (push) cmd_valid <= 1'b0;
    end
    if (accept) cmd <= decoded;
  end

endmodule

// ===== hw/rtl/ssbpd_queue.sv =====
// Short command queue between the front and back ends.
// Depends on ssbpd_pkg for the command type and depth.
module ssbpd_queue import ssbpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_pop,
  output cmd_t rd_cmd
);

  cmd_t             slots [QUEUE_DEPTH];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != QCntW'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
    if (do_wr) slots[wr_ptr] <= wr_cmd;
  end

endmodule

// ===== hw/rtl/ssbpd_back.sv =====
// Back end: owns both bitplanes, steps glyphs one segment per cycle, runs the
// frame counter and emits display register beats. Depends on ssbpd_pkg.
module ssbpd_back import ssbpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  input  logic [7:0] blink_frames,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       write_valid,
  output logic [3:0] reg_index,
  output logic [7:0] reg_data,
  output logic       frames_needed,
  output logic       last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLYPH,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [7:0]         plane_zero [REGISTER_COUNT];
  logic [7:0]         plane_one  [REGISTER_COUNT];
  logic [7:0]         p0_wr      [REGISTER_COUNT];
  logic [7:0]         p1_wr      [REGISTER_COUNT];
  logic               two_planes_used;
  logic               tpu_wr;
  logic [7:0]         frame_count;
  logic               shown_plane;
  logic               update_pending;
  cmd_t               cur;
  logic [2:0]         step;
  logic [RegIdxW-1:0] idx;
  logic               emit_all;

  logic [6:0] seg_sel;
  logic [1:0] dm_sel;
  logic [3:0] seg_reg;
  logic [7:0] seg_bit;
  logic       seg_req;
  logic       seg_we;
  logic [2:0] off_idx;
  logic [6:0] glyph_seg;
  logic       differ;
  logic [7:0] fc_inc;
  logic       swap;
  logic       out_load;
  logic       idx_last;
  logic [7:0] fill_byte;

  assign q_pop = (state == ST_IDLE) && q_valid;

  // Glyph segment for the current step; an inverted display walks the offsets backward.
  assign off_idx   = cur.flip ? (LAST_STEP - step) : step;
  assign glyph_seg = 7'(cur.base) + 7'(seg_offset(off_idx));

  always_comb begin
    seg_req = 1'b0;
    seg_sel = q_cmd.seg;
    dm_sel  = q_cmd.dmode;
    if (state == ST_GLYPH) begin
      seg_req = 1'b1;
      seg_sel = glyph_seg;
      dm_sel  = cur.bits[step] ? cur.dmode : DMODE_OFF;
    end else if (q_pop && (q_cmd.kind == MODE_SEG)) begin
      seg_req = 1'b1;
    end
  end

  assign seg_reg = seg_sel[6:3];
  assign seg_bit = 8'(1) << seg_sel[2:0];
  assign seg_we  = seg_req && (seg_reg < 4'(REGISTER_COUNT));

  always_comb begin
    differ = 1'b0;
    for (int j = 0; j < REGISTER_COUNT; j++) begin
      p0_wr[j] = plane_zero[j];
      p1_wr[j] = plane_one[j];
      if (seg_reg == 4'(j)) begin
        p0_wr[j] = dm_sel[0] ? (plane_zero[j] | seg_bit) : (plane_zero[j] & ~seg_bit);
        p1_wr[j] = dm_sel[1] ? (plane_one[j] | seg_bit) : (plane_one[j] & ~seg_bit);
      end
      differ = differ | (p0_wr[j] != p1_wr[j]);
    end
  end

  // Blink modes always mark both planes in use; steady modes only clear the
  // mark once the planes agree again.
  always_comb begin
    if (dm_sel == DMODE_BLINK_A || dm_sel == DMODE_BLINK_B) tpu_wr = 1'b1;
    else if (!two_planes_used) tpu_wr = 1'b0;
    else tpu_wr = differ;
  end

  assign fc_inc    = frame_count + 8'd1;
  assign swap      = fc_inc > blink_frames;
  assign out_load  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign idx_last  = idx == RegIdxW'(REGISTER_COUNT - 1);
  assign fill_byte = (q_cmd.dmode == DMODE_ON) ? 8'hFF : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      two_planes_used <= 1'b0;
      frame_count     <= '0;
      shown_plane     <= 1'b0;
      update_pending  <= 1'b0;
      out_valid       <= 1'b0;
      step            <= '0;
      idx             <= '0;
      emit_all        <= 1'b0;
      for (int j = 0; j < REGISTER_COUNT; j++) begin
        plane_zero[j] <= '0;
        plane_one[j]  <= '0;
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (seg_we) begin
        for (int j = 0; j < REGISTER_COUNT; j++) begin
          plane_zero[j] <= p0_wr[j];
          plane_one[j]  <= p1_wr[j];
        end
        two_planes_used <= tpu_wr;
      end

      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              MODE_GLYPH: begin
                step  <= '0;
                state <= ST_GLYPH;
              end
              MODE_FILL: begin
                for (int j = 0; j < REGISTER_COUNT; j++) begin
                  plane_zero[j] <= fill_byte;
                  plane_one[j]  <= fill_byte;
                end
                two_planes_used <= 1'b0;
                update_pending  <= 1'b1;
              end
              MODE_REQ: update_pending <= 1'b1;
              MODE_TICK: begin
                frame_count    <= swap ? 8'd0 : fc_inc;
                shown_plane    <= shown_plane ^ swap;
                emit_all       <= update_pending | swap;
                update_pending <= 1'b0;
                idx            <= '0;
                state          <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_GLYPH: begin
          step <= step + 3'd1;
          if (step == LAST_STEP) state <= ST_IDLE;
        end
        ST_EMIT: begin
          if (out_load) begin
            write_valid   <= emit_all;
            reg_index     <= emit_all ? 4'(idx) : 4'd0;
            reg_data      <= emit_all ? (shown_plane ? plane_one[idx] : plane_zero[idx]) : 8'd0;
            frames_needed <= two_planes_used;
            last          <= !emit_all || idx_last;
            if (!emit_all || idx_last) state <= ST_IDLE;
            else idx <= idx + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the glyph command on dispatch.
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.kind == MODE_GLYPH)) cur <= q_cmd;
  end

endmodule

// ===== hw/rtl/ssbpd_checker.sv =====
// Port-level checks on the result stream of the blink plane driver, bound to the top.
// Depends on ssbpd_pkg and seven_segment_blink_plane_driver.
module ssbpd_checker import ssbpd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // A tick without an update is a single, empty, closing beat.
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tlast && (m_axis_tdata[11:0] == 12'd0))
    else $error("status beat carries register data or is not last");

  // Register beats address existing registers and close only on the highest one.
  a_reg_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[3:0] < 4'(REGISTER_COUNT)) &&
      (m_axis_tlast == (m_axis_tdata[3:0] == 4'(REGISTER_COUNT - 1))))
    else $error("register beat index or last flag wrong");

endmodule

bind seven_segment_blink_plane_driver ssbpd_checker u_ssbpd_checker (.*);
